/* sv/fls_pkg.sv */
package fls_pkg;

  localparam int COORD_BITS_DEF = 32;
  localparam int LIMB_BITS      = 32;   // partial-product operand width
  localparam int MUL_LAT        = 5;    // register stages inside fls_mul
  localparam int Q_BITS         = 16;   // intensity width, one root step per bit
  localparam int SCALE_SHIFT    = 30;   // Q1.15 squared

  localparam logic [Q_BITS-1:0] FULL_SCALE = Q_BITS'(32768);
  localparam logic [Q_BITS-1:0] ZERO_SCALE = '0;

  localparam logic [1:0] REG_LIGHT_X = 2'd0;
  localparam logic [1:0] REG_LIGHT_Y = 2'd1;
  localparam logic [1:0] REG_LIGHT_Z = 2'd2;

  typedef struct packed {
    logic degen;   // zero-length normal or light vector
    logic away;    // dot product not positive
  } shade_flags_t;

endpackage

/* sv/fls_tri_if.sv */
interface fls_tri_if import fls_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] v0_x;
  logic signed [COORD_BITS-1:0] v0_y;
  logic signed [COORD_BITS-1:0] v0_z;
  logic signed [COORD_BITS-1:0] v1_x;
  logic signed [COORD_BITS-1:0] v1_y;
  logic signed [COORD_BITS-1:0] v1_z;
  logic signed [COORD_BITS-1:0] v2_x;
  logic signed [COORD_BITS-1:0] v2_y;
  logic signed [COORD_BITS-1:0] v2_z;

  modport source (
    output valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z,
    input  ready
  );
  modport sink (
    input  valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z,
    output ready
  );
endinterface

/* sv/fls_shade_if.sv */
interface fls_shade_if import fls_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [Q_BITS-1:0] intensity;
  logic              degenerate;

  modport source (output valid, intensity, degenerate, input ready);
  modport sink   (input valid, intensity, degenerate, output ready);
endinterface

/* sv/fls_mul.sv */
// Signed multiplier: magnitude, 32x32 partial products, row sums, total, sign.
module fls_mul import fls_pkg::*; #(
  parameter int AW = 32,
  parameter int BW = 32
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [AW-1:0]    a,
  input  logic signed [BW-1:0]    b,
  output logic signed [AW+BW-1:0] p
);

  localparam int NA   = (AW + LIMB_BITS - 1) / LIMB_BITS;
  localparam int NB   = (BW + LIMB_BITS - 1) / LIMB_BITS;
  localparam int AP   = NA * LIMB_BITS;
  localparam int BP   = NB * LIMB_BITS;
  localparam int RWD  = LIMB_BITS * (NB + 1);
  localparam int SUMW = AP + BP;
  localparam int PWD  = AW + BW;

  logic [AP-1:0]            ma;
  logic [BP-1:0]            mb;
  logic                     sg1, sg2, sg3, sg4;
  logic [2*LIMB_BITS-1:0]   pp [NA][NB];
  logic [RWD-1:0]           row [NA];
  logic [RWD-1:0]           row_next [NA];
  logic [SUMW-1:0]          mag;
  logic [SUMW-1:0]          mag_next;

  always_comb begin
    for (int i = 0; i < NA; i++) begin
      row_next[i] = '0;
      for (int j = 0; j < NB; j++) begin
        row_next[i] = row_next[i] + (RWD'(pp[i][j]) << (LIMB_BITS * j));
      end
    end
  end

  always_comb begin
    mag_next = '0;
    for (int i = 0; i < NA; i++) begin
      mag_next = mag_next + (SUMW'(row[i]) << (LIMB_BITS * i));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ma  <= AP'($unsigned(a[AW-1] ? -a : a));
      mb  <= BP'($unsigned(b[BW-1] ? -b : b));
      sg1 <= a[AW-1] ^ b[BW-1];
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp[i][j] <= ma[i*LIMB_BITS +: LIMB_BITS] * mb[j*LIMB_BITS +: LIMB_BITS];
        end
      end
      sg2 <= sg1;
      row <= row_next;
      sg3 <= sg2;
      mag <= mag_next;
      sg4 <= sg3;
      p   <= sg4 ? -$signed(PWD'(mag)) : $signed(PWD'(mag));
    end
  end

endmodule

/* sv/fls_dly.sv */
// Side-band delay line that moves with the pipeline enable.
module fls_dly #(
  parameter int W = 8,
  parameter int N = 4
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] sr [N];

  always_ff @(posedge clk) begin
    if (en) begin
      sr[0] <= d;
      for (int i = 1; i < N; i++) begin
        sr[i] <= sr[i-1];
      end
    end
  end

  assign q = sr[N-1];

endmodule

/* sv/flat_triangle_lambert_shade_unit.sv */
// Throughput: one triangle per cycle; the pipeline advances as a whole and
// holds while an output beat waits. Depth is set by three rounds of 5-stage
// multipliers (cross product, squares and dot, final products) and the
// 16-stage root that finds the Q1.15 intensity one bit per stage.
// Reset clears the valid bits and the light registers.
module flat_triangle_lambert_shade_unit import fls_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  fls_tri_if.sink              tri_in,
  fls_shade_if.source          shade,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [((COORD_BITS > 32) ? 3 : 2)+1:0] paddr,
  input  logic [((COORD_BITS > 32) ? 64 : 32)-1:0] pwdata,
  output logic [((COORD_BITS > 32) ? 64 : 32)-1:0] prdata,
  output logic                 pready
);

  localparam int CB     = COORD_BITS;
  localparam int DATA_W = (CB > 32) ? 64 : 32;
  localparam int ALIGN  = (CB > 32) ? 3 : 2;
  localparam int EW     = CB + 1;           // edge
  localparam int S3W    = CB + 2;           // three-term sums
  localparam int DW     = CB + 3;           // light direction
  localparam int XW     = 2 * EW;           // cross partial product
  localparam int NW     = XW + 1;           // normal
  localparam int N2W    = 2 * NW + 2;
  localparam int D2W    = 2 * DW + 2;
  localparam int DTW    = NW + DW + 2;
  localparam int PW     = N2W + D2W;
  localparam int DSW    = 2 * DTW;
  localparam int RW     = DSW + SCALE_SHIFT;
  localparam int MW     = PW + 2 * Q_BITS + 2;
  localparam int SQW    = ((MW > RW) ? MW : RW) + 1;
  localparam int DEPTH  = 5 + 3 * MUL_LAT + Q_BITS;
  localparam int FW     = $bits(shade_flags_t);

  logic                 en;
  logic [DEPTH-1:0]     vld;

  // configuration
  logic signed [CB-1:0] light [3];
  logic [1:0]           cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[ALIGN +: 2];

  always_ff @(posedge clk) begin
    if (rst) begin
      light[0] <= '0;
      light[1] <= '0;
      light[2] <= '0;
    end else if (psel && penable && pwrite) begin
      case (cfg_idx)
        REG_LIGHT_X: light[0] <= pwdata[CB-1:0];
        REG_LIGHT_Y: light[1] <= pwdata[CB-1:0];
        REG_LIGHT_Z: light[2] <= pwdata[CB-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_LIGHT_X: prdata = DATA_W'(light[0]);
      REG_LIGHT_Y: prdata = DATA_W'(light[1]);
      REG_LIGHT_Z: prdata = DATA_W'(light[2]);
      default:     prdata = '0;
    endcase
  end

  // handshake
  assign en           = !vld[DEPTH-1] || shade.ready;
  assign tri_in.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DEPTH-2:0], tri_in.valid};
    end
  end

  // stage 0: input register
  logic signed [CB-1:0] pin [9];

  always_ff @(posedge clk) begin
    if (en) begin
      pin[0] <= tri_in.v0_x;
      pin[1] <= tri_in.v0_y;
      pin[2] <= tri_in.v0_z;
      pin[3] <= tri_in.v1_x;
      pin[4] <= tri_in.v1_y;
      pin[5] <= tri_in.v1_z;
      pin[6] <= tri_in.v2_x;
      pin[7] <= tri_in.v2_y;
      pin[8] <= tri_in.v2_z;
    end
  end

  // stage 1: edges, vertex sum, 3L; stage 2: direction
  logic signed [EW-1:0]  e1 [3];
  logic signed [EW-1:0]  e2 [3];
  logic signed [S3W-1:0] vs [3];
  logic signed [S3W-1:0] l3 [3];
  logic signed [DW-1:0]  dir [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        e1[a]  <= EW'(pin[a+3]) - EW'(pin[a]);
        e2[a]  <= EW'(pin[a+6]) - EW'(pin[a]);
        vs[a]  <= S3W'(pin[a]) + S3W'(pin[a+3]) + S3W'(pin[a+6]);
        l3[a]  <= S3W'(light[a]) + (S3W'(light[a]) <<< 1);
        dir[a] <= DW'(l3[a]) - DW'(vs[a]);
      end
    end
  end

  // cross product
  logic signed [XW-1:0] xa [3];
  logic signed [XW-1:0] xb [3];

  for (genvar a = 0; a < 3; a++) begin : g_cross
    localparam int U = (a + 1) % 3;
    localparam int V = (a + 2) % 3;
    fls_mul #(.AW(EW), .BW(EW)) u_xa (
      .clk(clk), .en(en), .a(e1[U]), .b(e2[V]), .p(xa[a])
    );
    fls_mul #(.AW(EW), .BW(EW)) u_xb (
      .clk(clk), .en(en), .a(e1[V]), .b(e2[U]), .p(xb[a])
    );
  end

  logic [3*DW-1:0] dir_dly;

  fls_dly #(.W(3*DW), .N(MUL_LAT-1)) u_dir_dly (
    .clk(clk), .en(en), .d({dir[2], dir[1], dir[0]}), .q(dir_dly)
  );

  // normal and aligned direction
  logic signed [NW-1:0] nv [3];
  logic signed [DW-1:0] dv [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        nv[a] <= NW'(xa[a]) - NW'(xb[a]);
        dv[a] <= dir_dly[a*DW +: DW];
      end
    end
  end

  // squares and dot terms
  logic signed [2*NW-1:0]  nn [3];
  logic signed [2*DW-1:0]  ddq [3];
  logic signed [NW+DW-1:0] nd [3];

  for (genvar a = 0; a < 3; a++) begin : g_sq
    fls_mul #(.AW(NW), .BW(NW)) u_nn (
      .clk(clk), .en(en), .a(nv[a]), .b(nv[a]), .p(nn[a])
    );
    fls_mul #(.AW(DW), .BW(DW)) u_dd (
      .clk(clk), .en(en), .a(dv[a]), .b(dv[a]), .p(ddq[a])
    );
    fls_mul #(.AW(NW), .BW(DW)) u_nd (
      .clk(clk), .en(en), .a(nv[a]), .b(dv[a]), .p(nd[a])
    );
  end

  logic signed [N2W-1:0] n2;
  logic signed [D2W-1:0] d2;
  logic signed [DTW-1:0] dot;
  shade_flags_t          flg;

  always_ff @(posedge clk) begin
    if (en) begin
      n2        <= N2W'(nn[0]) + N2W'(nn[1]) + N2W'(nn[2]);
      d2        <= D2W'(ddq[0]) + D2W'(ddq[1]) + D2W'(ddq[2]);
      dot       <= DTW'(nd[0]) + DTW'(nd[1]) + DTW'(nd[2]);
      flg.degen <= (n2 == '0) || (d2 == '0);
      flg.away  <= dot[DTW-1] || (dot == '0);
    end
  end

  // |n|^2 |d|^2 and dot^2
  logic signed [PW-1:0]  prod;
  logic signed [DSW-1:0] dsq;
  logic [FW-1:0]         flg_dly;

  fls_mul #(.AW(N2W), .BW(D2W)) u_prod (
    .clk(clk), .en(en), .a(n2), .b(d2), .p(prod)
  );
  fls_mul #(.AW(DTW), .BW(DTW)) u_dsq (
    .clk(clk), .en(en), .a(dot), .b(dot), .p(dsq)
  );
  fls_dly #(.W(FW), .N(MUL_LAT-1)) u_flg_dly (
    .clk(clk), .en(en), .d(flg), .q(flg_dly)
  );

  // root: largest q with q^2 * prod <= dot^2 * 2^30, q <= full scale.
  // m tracks q * prod, r the remaining right-hand side.
  logic [Q_BITS-1:0] sq_q [Q_BITS+1];
  shade_flags_t      sq_f [Q_BITS+1];
  logic [SQW-1:0]    sq_m [Q_BITS];
  logic [SQW-1:0]    sq_r [Q_BITS];
  logic [SQW-1:0]    sq_p [Q_BITS];

  assign sq_q[0] = '0;
  assign sq_f[0] = flg_dly;
  assign sq_m[0] = '0;
  assign sq_r[0] = SQW'($unsigned(dsq)) << SCALE_SHIFT;
  assign sq_p[0] = SQW'($unsigned(prod));

  for (genvar g = 0; g < Q_BITS; g++) begin : g_root
    localparam int K = Q_BITS - 1 - g;
    logic [SQW-1:0] delta;
    logic           take;

    always_comb begin
      delta = (sq_m[g] << (K + 1)) + (sq_p[g] << (2 * K));
      take  = ((K == Q_BITS - 1) || !sq_q[g][Q_BITS-1]) && (delta <= sq_r[g]);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_q[g+1] <= take ? (sq_q[g] | (Q_BITS'(1) << K)) : sq_q[g];
        sq_f[g+1] <= sq_f[g];
      end
    end

    if (g < Q_BITS - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          sq_m[g+1] <= take ? (sq_m[g] + (sq_p[g] << K)) : sq_m[g];
          sq_r[g+1] <= take ? (sq_r[g] - delta) : sq_r[g];
          sq_p[g+1] <= sq_p[g];
        end
      end
    end
  end

  // output register
  logic [Q_BITS-1:0] out_int;
  logic              out_deg;

  always_ff @(posedge clk) begin
    if (en) begin
      out_deg <= sq_f[Q_BITS].degen;
      if (sq_f[Q_BITS].degen) begin
        out_int <= FULL_SCALE;
      end else if (sq_f[Q_BITS].away) begin
        out_int <= ZERO_SCALE;
      end else begin
        out_int <= sq_q[Q_BITS];
      end
    end
  end

  assign shade.valid      = vld[DEPTH-1];
  assign shade.intensity  = out_int;
  assign shade.degenerate = out_deg;

endmodule
